// ===== design/ray_triangle_intersect_assert.svh =====
// Assertion macros for the ray/triangle unit.
// Both expect aclk and aresetn to be visible where they are used.
`ifndef RAY_TRIANGLE_INTERSECT_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_ASSERT_SVH

// Same-cycle implication.
`define RTI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ray_triangle_intersect: same-cycle check failed");

// Next-cycle implication.
`define RTI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ray_triangle_intersect: next-cycle check failed");

`endif

// ===== design/rti_pkg.sv =====
package rti_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int IN_W   = 32;
    localparam int DIST_W = 31;
    localparam int WGT_W  = 17;

    localparam int WEIGHT_SHIFT = 16;
    localparam int NUM_VERTS    = 3;

    localparam logic [DIST_W-1:0] DIST_ALL_ONES  = 31'h7FFF_FFFF;
    localparam logic [DIST_W-1:0] MIN_DIST_RESET = 31'd66;
    localparam logic [WGT_W-1:0]  WEIGHT_ONE     = 17'd65536;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_RAY  = 1'b1
    } cmd_t;

endpackage

// ===== design/rti_div.sv =====
module rti_div #(
    parameter int CW    = 32,
    parameter int SHIFT = 16,
    parameter int TAG_W = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 vld_i,
    input  logic signed [CW-1:0] num_i,
    input  logic signed [CW-1:0] den_i,
    input  logic [TAG_W-1:0]     tag_i,
    output logic                 vld_o,
    output logic signed [CW-1:0] quo_o,
    output logic [TAG_W-1:0]     tag_o
);

    // Restoring divider, one quotient bit per stage.
    localparam int STEPS = CW + SHIFT;
    localparam logic [CW:0] HALF = (CW+1)'(1) << (CW - 1);

    logic [CW:0]      rem_reg [0:STEPS];
    logic [CW-1:0]    q_reg   [0:STEPS];
    logic [CW-1:0]    mn_reg  [0:STEPS];
    logic [CW-1:0]    md_reg  [0:STEPS];
    logic             neg_reg [0:STEPS];
    logic [TAG_W-1:0] tag_reg [0:STEPS];
    logic             vld_reg [0:STEPS];

    logic                 out_vld_reg;
    logic signed [CW-1:0] quo_reg;
    logic [TAG_W-1:0]     out_tag_reg;
    logic [CW:0]          q_fin;
    logic [CW:0]          lim;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= vld_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mn_reg[0]  <= num_i[CW-1] ? -num_i : num_i;
            md_reg[0]  <= den_i[CW-1] ? -den_i : den_i;
            neg_reg[0] <= num_i[CW-1] ^ den_i[CW-1];
            rem_reg[0] <= '0;
            q_reg[0]   <= '0;
            tag_reg[0] <= tag_i;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam int I = STEPS - 1 - k;
        logic        nbit;
        logic [CW:0] rem_sh;
        logic        ge;
        logic [CW:0] rem_nx;
        logic [CW:0] q_sh;
        logic [CW:0] q_cap;
        logic [CW:0] q_nx;

        if (I >= SHIFT) begin : g_num
            assign nbit = mn_reg[k][I-SHIFT];
        end else begin : g_zero
            assign nbit = 1'b0;
        end

        always_comb begin
            rem_sh = {rem_reg[k][CW-1:0], nbit};
            ge     = rem_sh >= {1'b0, md_reg[k]};
            rem_nx = ge ? rem_sh - {1'b0, md_reg[k]} : rem_sh;
            q_sh   = {q_reg[k], ge};
            // hold the running quotient just past the limit
            q_cap  = HALF + (CW+1)'(neg_reg[k]);
            q_nx   = (q_sh > q_cap) ? q_cap : q_sh;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= rem_nx;
                q_reg[k+1]   <= q_nx[CW-1:0];
                mn_reg[k+1]  <= mn_reg[k];
                md_reg[k+1]  <= md_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    always_comb begin
        lim   = HALF - (CW+1)'(1) + (CW+1)'(neg_reg[STEPS]);
        q_fin = {1'b0, q_reg[STEPS]};
        if (q_fin > lim) begin
            q_fin = lim;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= vld_reg[STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg     <= neg_reg[STEPS] ? -q_fin[CW-1:0] : q_fin[CW-1:0];
            out_tag_reg <= tag_reg[STEPS];
        end
    end

    assign vld_o = out_vld_reg;
    assign quo_o = quo_reg;
    assign tag_o = out_tag_reg;

endmodule

// ===== design/ray_triangle_intersect.sv =====
// Ray/triangle edge test, fully pipelined: one item per cycle when m_ready is high.
// A ray item passes the front-end stages, the bit-per-stage distance divider, the back-end
// stages and then the three parallel weight dividers; coordinates are Q16.16 by default.
// Load items with a valid vertex select update the stored triangle at once and produce no result.
// Synchronous active-low reset clears the pipeline valids and the vertices and sets min_distance to 66.
module ray_triangle_intersect #(
    parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rti_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [rti_pkg::DIST_W-1:0]       cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_cmd,
    input  logic [1:0]                       s_vertex_sel,
    input  logic signed [rti_pkg::IN_W-1:0]  s_vert_x,
    input  logic signed [rti_pkg::IN_W-1:0]  s_vert_y,
    input  logic signed [rti_pkg::IN_W-1:0]  s_vert_z,
    input  logic signed [rti_pkg::IN_W-1:0]  s_origin_x,
    input  logic signed [rti_pkg::IN_W-1:0]  s_origin_y,
    input  logic signed [rti_pkg::IN_W-1:0]  s_origin_z,
    input  logic signed [rti_pkg::IN_W-1:0]  s_dir_x,
    input  logic signed [rti_pkg::IN_W-1:0]  s_dir_y,
    input  logic signed [rti_pkg::IN_W-1:0]  s_dir_z,
    input  logic [rti_pkg::DIST_W-1:0]       s_max_distance,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_hit,
    output logic [rti_pkg::DIST_W-1:0]       m_hit_distance,
    output logic [rti_pkg::WGT_W-1:0]        m_weight_first,
    output logic [rti_pkg::WGT_W-1:0]        m_weight_second,
    output logic [rti_pkg::WGT_W-1:0]        m_weight_third
);
    import rti_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int XW = 2 * CW + 2;
    localparam logic signed [XW-1:0] FX_MAX_W  = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [XW-1:0] FX_MIN_W  = ~FX_MAX_W;
    localparam logic signed [XW-1:0] DIST_MAX_W = XW'(DIST_ALL_ONES);
    localparam logic signed [XW-1:0] WONE_W     = XW'(WEIGHT_ONE);

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } vec_t;

    typedef struct packed {
        vec_t              o;
        vec_t              d;
        vec_t              p1;
        vec_t              p2;
        vec_t              p3;
        logic [DIST_W-1:0] maxd;
    } ray_t;

    typedef struct packed {
        ray_t                 ray;
        vec_t                 e12;
        vec_t                 e23;
        vec_t                 e31;
        vec_t                 n;
        logic signed [CW-1:0] nn;
        logic                 miss;
    } tag_t;

    typedef struct packed {
        logic                 miss;
        logic signed [CW-1:0] t;
    } wtag_t;

    localparam int TAG_W  = $bits(tag_t);
    localparam int WTAG_W = $bits(wtag_t);

    function automatic logic signed [CW-1:0] fx_sat(input logic signed [XW-1:0] a);
        if (a > FX_MAX_W) return FX_MAX_W[CW-1:0];
        if (a < FX_MIN_W) return FX_MIN_W[CW-1:0];
        return a[CW-1:0];
    endfunction

    function automatic logic signed [CW-1:0] fx_add(input logic signed [CW-1:0] a,
                                                    input logic signed [CW-1:0] b);
        return fx_sat(XW'(a) + XW'(b));
    endfunction

    function automatic logic signed [CW-1:0] fx_sub(input logic signed [CW-1:0] a,
                                                    input logic signed [CW-1:0] b);
        return fx_sat(XW'(a) - XW'(b));
    endfunction

    function automatic logic signed [CW-1:0] fx_mul(input logic signed [CW-1:0] a,
                                                    input logic signed [CW-1:0] b);
        logic            neg;
        logic [CW-1:0]   ma;
        logic [CW-1:0]   mb;
        logic [2*CW-1:0] prod;
        logic [2*CW-1:0] sh;
        logic [2*CW-1:0] lim;
        neg  = a[CW-1] ^ b[CW-1];
        ma   = a[CW-1] ? -a : a;
        mb   = b[CW-1] ? -b : b;
        prod = {{CW{1'b0}}, ma} * {{CW{1'b0}}, mb};
        sh   = prod >> FRAC_BITS;
        lim  = {{(CW+1){1'b0}}, {(CW-1){1'b1}}} + {{(2*CW-1){1'b0}}, neg};
        if (sh > lim) sh = lim;
        return neg ? -sh[CW-1:0] : sh[CW-1:0];
    endfunction

    function automatic vec_t v_sub(input vec_t a, input vec_t b);
        vec_t r;
        r.x = fx_sub(a.x, b.x);
        r.y = fx_sub(a.y, b.y);
        r.z = fx_sub(a.z, b.z);
        return r;
    endfunction

    function automatic vec_t v_add(input vec_t a, input vec_t b);
        vec_t r;
        r.x = fx_add(a.x, b.x);
        r.y = fx_add(a.y, b.y);
        r.z = fx_add(a.z, b.z);
        return r;
    endfunction

    function automatic vec_t v_mul(input vec_t a, input vec_t b);
        vec_t r;
        r.x = fx_mul(a.x, b.x);
        r.y = fx_mul(a.y, b.y);
        r.z = fx_mul(a.z, b.z);
        return r;
    endfunction

    function automatic vec_t v_scale(input logic signed [CW-1:0] s, input vec_t b);
        vec_t r;
        r.x = fx_mul(s, b.x);
        r.y = fx_mul(s, b.y);
        r.z = fx_mul(s, b.z);
        return r;
    endfunction

    // positive and negative halves of a cross product
    function automatic vec_t cross_pos(input vec_t a, input vec_t b);
        vec_t r;
        r.x = fx_mul(a.y, b.z);
        r.y = fx_mul(a.z, b.x);
        r.z = fx_mul(a.x, b.y);
        return r;
    endfunction

    function automatic vec_t cross_neg(input vec_t a, input vec_t b);
        vec_t r;
        r.x = fx_mul(a.z, b.y);
        r.y = fx_mul(a.x, b.z);
        r.z = fx_mul(a.y, b.x);
        return r;
    endfunction

    function automatic logic signed [CW-1:0] sum3(input vec_t a);
        return fx_add(fx_add(a.x, a.y), a.z);
    endfunction

    function automatic vec_t in_vec(input logic signed [IN_W-1:0] x,
                                    input logic signed [IN_W-1:0] y,
                                    input logic signed [IN_W-1:0] z);
        vec_t r;
        r.x = fx_sat(XW'(x));
        r.y = fx_sat(XW'(y));
        r.z = fx_sat(XW'(z));
        return r;
    endfunction

    function automatic logic [WGT_W-1:0] w_clamp(input logic signed [CW-1:0] q);
        logic signed [XW-1:0] qx;
        qx = XW'(q);
        if (qx < 0) return '0;
        if (qx > WONE_W) return WEIGHT_ONE;
        return qx[WGT_W-1:0];
    endfunction

    logic adv;
    logic acc;

    logic [DIST_W-1:0] min_dist_reg;
    vec_t              vtx_reg [0:NUM_VERTS-1];

    // stage registers
    logic a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg, e_vld_reg, f_vld_reg;
    logic g_vld_reg, h_vld_reg, i_vld_reg, j_vld_reg, k_vld_reg, l_vld_reg, m_vld_reg;
    logic out_vld_reg;

    ray_t a_ray_reg, b_ray_reg, c_ray_reg, d_ray_reg, e_ray_reg, f_ray_reg;
    vec_t b_e12_reg, b_e23_reg, b_e31_reg, b_po_reg;
    vec_t c_e12_reg, c_e23_reg, c_e31_reg, c_po_reg, c_npa_reg, c_npb_reg;
    vec_t d_e12_reg, d_e23_reg, d_e31_reg, d_po_reg, d_n_reg;
    vec_t e_e12_reg, e_e23_reg, e_e31_reg, e_n_reg, e_nn_reg, e_dn_reg, e_num_reg;
    vec_t f_e12_reg, f_e23_reg, f_e31_reg, f_n_reg;
    logic signed [CW-1:0] f_nn_reg, f_dn_reg, f_num_reg;
    logic f_miss_reg;

    tag_t tag_f;
    tag_t tag_div;
    logic [TAG_W-1:0] tdiv_tag;
    logic             tdiv_vld;
    logic signed [CW-1:0] tdiv_q;
    logic                 t_short;
    logic                 t_long;

    tag_t g_tag_reg, h_tag_reg, i_tag_reg, j_tag_reg, k_tag_reg, l_tag_reg, m_tag_reg;
    logic signed [CW-1:0] g_t_reg, h_t_reg, i_t_reg, j_t_reg, k_t_reg, l_t_reg, m_t_reg;
    logic g_miss_reg, h_miss_reg, i_miss_reg, j_miss_reg, k_miss_reg, l_miss_reg;
    logic m_miss_reg;
    vec_t g_td_reg;
    vec_t h_pi_reg;
    vec_t i_r1_reg, i_r2_reg, i_r3_reg;
    vec_t j_ua_reg, j_ub_reg, j_va_reg, j_vb_reg, j_wa_reg, j_wb_reg;
    vec_t k_cu_reg, k_cv_reg, k_cw_reg;
    vec_t l_pu_reg, l_pv_reg, l_pw_reg;
    logic signed [CW-1:0] m_u_reg, m_v_reg, m_w_reg;

    wtag_t            wtag_m;
    wtag_t            wtag_out;
    logic [WTAG_W-1:0] wdiv_tag;
    logic              wdiv_vld;
    logic signed [CW-1:0] wq_first, wq_second, wq_third;

    logic              out_hit_reg;
    logic [DIST_W-1:0] out_dist_reg;
    logic [WGT_W-1:0]  out_w1_reg, out_w2_reg, out_w3_reg;

    // the whole pipeline moves together; it holds only while a result waits
    assign adv     = !out_vld_reg || m_ready;
    assign s_ready = adv;
    assign acc     = s_valid && adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_dist_reg <= MIN_DIST_RESET;
        end else if (cfg_wr_en) begin
            min_dist_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int v = 0; v < NUM_VERTS; v++) begin
                vtx_reg[v] <= '0;
            end
        end else if (acc && s_cmd == CMD_LOAD && s_vertex_sel < 2'(NUM_VERTS)) begin
            vtx_reg[s_vertex_sel] <= in_vec(s_vert_x, s_vert_y, s_vert_z);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            g_vld_reg   <= 1'b0;
            h_vld_reg   <= 1'b0;
            i_vld_reg   <= 1'b0;
            j_vld_reg   <= 1'b0;
            k_vld_reg   <= 1'b0;
            l_vld_reg   <= 1'b0;
            m_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            a_vld_reg   <= acc && s_cmd == CMD_RAY;
            b_vld_reg   <= a_vld_reg;
            c_vld_reg   <= b_vld_reg;
            d_vld_reg   <= c_vld_reg;
            e_vld_reg   <= d_vld_reg;
            f_vld_reg   <= e_vld_reg;
            g_vld_reg   <= tdiv_vld;
            h_vld_reg   <= g_vld_reg;
            i_vld_reg   <= h_vld_reg;
            j_vld_reg   <= i_vld_reg;
            k_vld_reg   <= j_vld_reg;
            l_vld_reg   <= k_vld_reg;
            m_vld_reg   <= l_vld_reg;
            out_vld_reg <= wdiv_vld;
        end
    end

    // front end: normal, N.N, d.N and the distance numerator
    always_ff @(posedge aclk) begin
        if (adv) begin
            a_ray_reg.o    <= in_vec(s_origin_x, s_origin_y, s_origin_z);
            a_ray_reg.d    <= in_vec(s_dir_x, s_dir_y, s_dir_z);
            a_ray_reg.p1   <= vtx_reg[0];
            a_ray_reg.p2   <= vtx_reg[1];
            a_ray_reg.p3   <= vtx_reg[2];
            a_ray_reg.maxd <= s_max_distance;

            b_ray_reg <= a_ray_reg;
            b_e12_reg <= v_sub(a_ray_reg.p2, a_ray_reg.p1);
            b_e23_reg <= v_sub(a_ray_reg.p3, a_ray_reg.p2);
            b_e31_reg <= v_sub(a_ray_reg.p1, a_ray_reg.p3);
            b_po_reg  <= v_sub(a_ray_reg.p1, a_ray_reg.o);

            c_ray_reg <= b_ray_reg;
            c_e12_reg <= b_e12_reg;
            c_e23_reg <= b_e23_reg;
            c_e31_reg <= b_e31_reg;
            c_po_reg  <= b_po_reg;
            c_npa_reg <= cross_pos(b_e12_reg, b_e23_reg);
            c_npb_reg <= cross_neg(b_e12_reg, b_e23_reg);

            d_ray_reg <= c_ray_reg;
            d_e12_reg <= c_e12_reg;
            d_e23_reg <= c_e23_reg;
            d_e31_reg <= c_e31_reg;
            d_po_reg  <= c_po_reg;
            d_n_reg   <= v_sub(c_npa_reg, c_npb_reg);

            e_ray_reg <= d_ray_reg;
            e_e12_reg <= d_e12_reg;
            e_e23_reg <= d_e23_reg;
            e_e31_reg <= d_e31_reg;
            e_n_reg   <= d_n_reg;
            e_nn_reg  <= v_mul(d_n_reg, d_n_reg);
            e_dn_reg  <= v_mul(d_ray_reg.d, d_n_reg);
            e_num_reg <= v_mul(d_po_reg, d_n_reg);

            f_ray_reg  <= e_ray_reg;
            f_e12_reg  <= e_e12_reg;
            f_e23_reg  <= e_e23_reg;
            f_e31_reg  <= e_e31_reg;
            f_n_reg    <= e_n_reg;
            f_nn_reg   <= sum3(e_nn_reg);
            f_dn_reg   <= sum3(e_dn_reg);
            f_num_reg  <= sum3(e_num_reg);
            // parallel ray or degenerate triangle
            f_miss_reg <= sum3(e_nn_reg) <= 0 || sum3(e_dn_reg) == 0;
        end
    end

    always_comb begin
        tag_f.ray  = f_ray_reg;
        tag_f.e12  = f_e12_reg;
        tag_f.e23  = f_e23_reg;
        tag_f.e31  = f_e31_reg;
        tag_f.n    = f_n_reg;
        tag_f.nn   = f_nn_reg;
        tag_f.miss = f_miss_reg;
    end

    rti_div #(
        .CW    (CW),
        .SHIFT (FRAC_BITS),
        .TAG_W (TAG_W)
    ) u_tdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .vld_i   (f_vld_reg),
        .num_i   (f_num_reg),
        .den_i   (f_dn_reg),
        .tag_i   (tag_f),
        .vld_o   (tdiv_vld),
        .quo_o   (tdiv_q),
        .tag_o   (tdiv_tag)
    );

    always_comb begin
        tag_div = tag_t'(tdiv_tag);
        t_short = XW'(tdiv_q) < $signed(XW'(min_dist_reg));
        t_long  = tag_div.ray.maxd != DIST_ALL_ONES
                  && XW'(tdiv_q) > $signed(XW'(tag_div.ray.maxd));
    end

    // back end: hit point and the u, v and w edge terms
    always_ff @(posedge aclk) begin
        if (adv) begin
            g_tag_reg  <= tag_div;
            g_t_reg    <= tdiv_q;
            g_miss_reg <= tag_div.miss || t_short || t_long;
            g_td_reg   <= v_scale(tdiv_q, tag_div.ray.d);

            h_tag_reg  <= g_tag_reg;
            h_t_reg    <= g_t_reg;
            h_miss_reg <= g_miss_reg;
            h_pi_reg   <= v_add(g_tag_reg.ray.o, g_td_reg);

            i_tag_reg  <= h_tag_reg;
            i_t_reg    <= h_t_reg;
            i_miss_reg <= h_miss_reg;
            i_r1_reg   <= v_sub(h_pi_reg, h_tag_reg.ray.p1);
            i_r2_reg   <= v_sub(h_pi_reg, h_tag_reg.ray.p2);
            i_r3_reg   <= v_sub(h_pi_reg, h_tag_reg.ray.p3);

            j_tag_reg  <= i_tag_reg;
            j_t_reg    <= i_t_reg;
            j_miss_reg <= i_miss_reg;
            j_ua_reg   <= cross_pos(i_tag_reg.e12, i_r1_reg);
            j_ub_reg   <= cross_neg(i_tag_reg.e12, i_r1_reg);
            j_va_reg   <= cross_pos(i_tag_reg.e23, i_r2_reg);
            j_vb_reg   <= cross_neg(i_tag_reg.e23, i_r2_reg);
            j_wa_reg   <= cross_pos(i_tag_reg.e31, i_r3_reg);
            j_wb_reg   <= cross_neg(i_tag_reg.e31, i_r3_reg);

            k_tag_reg  <= j_tag_reg;
            k_t_reg    <= j_t_reg;
            k_miss_reg <= j_miss_reg;
            k_cu_reg   <= v_sub(j_ua_reg, j_ub_reg);
            k_cv_reg   <= v_sub(j_va_reg, j_vb_reg);
            k_cw_reg   <= v_sub(j_wa_reg, j_wb_reg);

            l_tag_reg  <= k_tag_reg;
            l_t_reg    <= k_t_reg;
            l_miss_reg <= k_miss_reg;
            l_pu_reg   <= v_mul(k_cu_reg, k_tag_reg.n);
            l_pv_reg   <= v_mul(k_cv_reg, k_tag_reg.n);
            l_pw_reg   <= v_mul(k_cw_reg, k_tag_reg.n);

            m_tag_reg  <= l_tag_reg;
            m_t_reg    <= l_t_reg;
            m_u_reg    <= sum3(l_pu_reg);
            m_v_reg    <= sum3(l_pv_reg);
            m_w_reg    <= sum3(l_pw_reg);
            // outside any edge drops the hit
            m_miss_reg <= l_miss_reg || sum3(l_pu_reg) < 0 || sum3(l_pv_reg) < 0
                          || sum3(l_pw_reg) < 0;
        end
    end

    always_comb begin
        wtag_m.miss = m_miss_reg;
        wtag_m.t    = m_t_reg;
        wtag_out    = wtag_t'(wdiv_tag);
    end

    rti_div #(
        .CW    (CW),
        .SHIFT (WEIGHT_SHIFT),
        .TAG_W (WTAG_W)
    ) u_wdiv_first (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .vld_i   (m_vld_reg),
        .num_i   (m_v_reg),
        .den_i   (m_tag_reg.nn),
        .tag_i   (wtag_m),
        .vld_o   (wdiv_vld),
        .quo_o   (wq_first),
        .tag_o   (wdiv_tag)
    );

    rti_div #(
        .CW    (CW),
        .SHIFT (WEIGHT_SHIFT),
        .TAG_W (1)
    ) u_wdiv_second (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .vld_i   (m_vld_reg),
        .num_i   (m_w_reg),
        .den_i   (m_tag_reg.nn),
        .tag_i   (1'b0),
        .vld_o   (),
        .quo_o   (wq_second),
        .tag_o   ()
    );

    rti_div #(
        .CW    (CW),
        .SHIFT (WEIGHT_SHIFT),
        .TAG_W (1)
    ) u_wdiv_third (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .vld_i   (m_vld_reg),
        .num_i   (m_u_reg),
        .den_i   (m_tag_reg.nn),
        .tag_i   (1'b0),
        .vld_o   (),
        .quo_o   (wq_third),
        .tag_o   ()
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_hit_reg <= !wtag_out.miss;
            if (wtag_out.miss) begin
                out_dist_reg <= DIST_ALL_ONES;
                out_w1_reg   <= '0;
                out_w2_reg   <= '0;
                out_w3_reg   <= '0;
            end else begin
                out_dist_reg <= (XW'(wtag_out.t) > DIST_MAX_W) ? DIST_ALL_ONES
                                                                : DIST_W'(wtag_out.t);
                out_w1_reg   <= w_clamp(wq_first);
                out_w2_reg   <= w_clamp(wq_second);
                out_w3_reg   <= w_clamp(wq_third);
            end
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_hit           = out_hit_reg;
    assign m_hit_distance  = out_dist_reg;
    assign m_weight_first  = out_w1_reg;
    assign m_weight_second = out_w2_reg;
    assign m_weight_third  = out_w3_reg;

endmodule

// ===== design/rti_checker.sv =====
`include "ray_triangle_intersect_assert.svh"

module rti_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             cfg_wr_en,
    input logic [rti_pkg::DIST_W-1:0]       cfg_wr_data,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             s_cmd,
    input logic [1:0]                       s_vertex_sel,
    input logic signed [rti_pkg::IN_W-1:0]  s_vert_x,
    input logic signed [rti_pkg::IN_W-1:0]  s_vert_y,
    input logic signed [rti_pkg::IN_W-1:0]  s_vert_z,
    input logic signed [rti_pkg::IN_W-1:0]  s_origin_x,
    input logic signed [rti_pkg::IN_W-1:0]  s_origin_y,
    input logic signed [rti_pkg::IN_W-1:0]  s_origin_z,
    input logic signed [rti_pkg::IN_W-1:0]  s_dir_x,
    input logic signed [rti_pkg::IN_W-1:0]  s_dir_y,
    input logic signed [rti_pkg::IN_W-1:0]  s_dir_z,
    input logic [rti_pkg::DIST_W-1:0]       s_max_distance,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic                             m_hit,
    input logic [rti_pkg::DIST_W-1:0]       m_hit_distance,
    input logic [rti_pkg::WGT_W-1:0]        m_weight_first,
    input logic [rti_pkg::WGT_W-1:0]        m_weight_second,
    input logic [rti_pkg::WGT_W-1:0]        m_weight_third
);
    import rti_pkg::*;

    // a waiting result holds
    `RTI_ASSERT_NXT(a_out_hold, m_valid && !m_ready,
                    m_valid && $stable(m_hit) && $stable(m_hit_distance))

    // a miss carries the fixed miss fields
    `RTI_ASSERT_IMP(a_miss_fields, m_valid && !m_hit,
                    m_hit_distance == DIST_ALL_ONES && m_weight_first == '0
                    && m_weight_second == '0 && m_weight_third == '0)

    // weights stay within one
    `RTI_ASSERT_IMP(a_weight_range, m_valid && m_hit,
                    m_weight_first <= WEIGHT_ONE && m_weight_second <= WEIGHT_ONE
                    && m_weight_third <= WEIGHT_ONE)

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import rti_pkg::*;

    localparam longint FX_HI = 64'sd2147483647;
    localparam longint FX_LO = -64'sd2147483648;
    localparam int RAY_LATENCY = 2 * 32 + 16 + 34;
    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEMS_PER_PHASE = 260;

    typedef struct {
        cmd_t                     cmd;
        logic [1:0]               sel;
        logic signed [IN_W-1:0]   vx, vy, vz;
        logic signed [IN_W-1:0]   ox, oy, oz;
        logic signed [IN_W-1:0]   dx, dy, dz;
        logic [DIST_W-1:0]        maxd;
    } tri_item_t;

    typedef struct {
        logic                hit;
        logic [DIST_W-1:0]   distance;
        logic [WGT_W-1:0]    w1, w2, w3;
    } hit_result_t;

    typedef struct {
        tri_item_t    item;
        bit           typed;
        hit_result_t  want;
    } stim_row_t;

    typedef struct {
        longint x, y, z;
    } fvec_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [DIST_W-1:0]        cfg_wr_data = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_cmd = 1'b0;
    logic [1:0]               s_vertex_sel = '0;
    logic signed [IN_W-1:0]   s_vert_x = '0, s_vert_y = '0, s_vert_z = '0;
    logic signed [IN_W-1:0]   s_origin_x = '0, s_origin_y = '0, s_origin_z = '0;
    logic signed [IN_W-1:0]   s_dir_x = '0, s_dir_y = '0, s_dir_z = '0;
    logic [DIST_W-1:0]        s_max_distance = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_hit;
    logic [DIST_W-1:0]        m_hit_distance;
    logic [WGT_W-1:0]         m_weight_first, m_weight_second, m_weight_third;

    ray_triangle_intersect dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_cmd(s_cmd), .s_vertex_sel(s_vertex_sel),
        .s_vert_x(s_vert_x), .s_vert_y(s_vert_y), .s_vert_z(s_vert_z),
        .s_origin_x(s_origin_x), .s_origin_y(s_origin_y), .s_origin_z(s_origin_z),
        .s_dir_x(s_dir_x), .s_dir_y(s_dir_y), .s_dir_z(s_dir_z),
        .s_max_distance(s_max_distance),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_hit(m_hit), .m_hit_distance(m_hit_distance),
        .m_weight_first(m_weight_first), .m_weight_second(m_weight_second),
        .m_weight_third(m_weight_third)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor state
    fvec_t             tri_vert [NUM_VERTS];
    longint            min_dist_reg;
    hit_result_t       pending_hits [$];
    stim_row_t         stim_rows [$];
    int                mismatches = 0;
    int                results_seen = 0;
    int                cycles = 0;
    bit                hold_done = 1'b0;

    function automatic longint sat(longint a);
        if (a > FX_HI) return FX_HI;
        if (a < FX_LO) return FX_LO;
        return a;
    endfunction

    function automatic longint fmul(longint a, longint b);
        bit neg;
        longint unsigned ma, mb, p, lim;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = (ma * mb) >> 16;
        lim = FX_HI + (neg ? 1 : 0);
        if (p > lim) p = lim;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint fdiv(longint num, longint den, int sh);
        bit neg;
        longint unsigned mn, md, q, lim;
        neg = (num < 0) != (den < 0);
        mn = (num < 0) ? -num : num;
        md = (den < 0) ? -den : den;
        q = (mn << sh) / md;
        lim = FX_HI + (neg ? 1 : 0);
        if (q > lim) q = lim;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic fvec_t vsub(fvec_t a, fvec_t b);
        fvec_t r;
        r.x = sat(a.x - b.x);
        r.y = sat(a.y - b.y);
        r.z = sat(a.z - b.z);
        return r;
    endfunction

    function automatic fvec_t vcross(fvec_t a, fvec_t b);
        fvec_t r;
        r.x = sat(fmul(a.y, b.z) - fmul(a.z, b.y));
        r.y = sat(fmul(a.z, b.x) - fmul(a.x, b.z));
        r.z = sat(fmul(a.x, b.y) - fmul(a.y, b.x));
        return r;
    endfunction

    function automatic longint vdot(fvec_t a, fvec_t b);
        return sat(sat(fmul(a.x, b.x) + fmul(a.y, b.y)) + fmul(a.z, b.z));
    endfunction

    function automatic longint clamp_weight(longint term, longint nn);
        longint q;
        q = fdiv(term, nn, WEIGHT_SHIFT);
        if (q < 0) return 0;
        return (q > 65536) ? 65536 : q;
    endfunction

    function automatic hit_result_t miss_result();
        hit_result_t r;
        r.hit = 1'b0;
        r.distance = DIST_ALL_ONES;
        r.w1 = '0;
        r.w2 = '0;
        r.w3 = '0;
        return r;
    endfunction

    function automatic hit_result_t trace_ray(tri_item_t it);
        fvec_t p1, p2, p3, o, d, e12, e23, n, pi;
        longint nn, dn, t, u, v, w;
        hit_result_t r;
        r = miss_result();
        p1 = tri_vert[0];
        p2 = tri_vert[1];
        p3 = tri_vert[2];
        o.x = it.ox; o.y = it.oy; o.z = it.oz;
        d.x = it.dx; d.y = it.dy; d.z = it.dz;
        e12 = vsub(p2, p1);
        e23 = vsub(p3, p2);
        n = vcross(e12, e23);
        nn = vdot(n, n);
        dn = vdot(d, n);
        if (nn <= 0 || dn == 0) return r;
        t = fdiv(vdot(vsub(p1, o), n), dn, 16);
        if (t < min_dist_reg) return r;
        if (it.maxd != DIST_ALL_ONES && t > longint'(it.maxd)) return r;
        pi.x = sat(o.x + fmul(t, d.x));
        pi.y = sat(o.y + fmul(t, d.y));
        pi.z = sat(o.z + fmul(t, d.z));
        u = vdot(vcross(e12, vsub(pi, p1)), n);
        if (u < 0) return r;
        v = vdot(vcross(e23, vsub(pi, p2)), n);
        if (v < 0) return r;
        w = vdot(vcross(vsub(p1, p3), vsub(pi, p3)), n);
        if (w < 0) return r;
        r.hit = 1'b1;
        r.distance = (t > FX_HI) ? DIST_ALL_ONES : DIST_W'(t);
        r.w1 = WGT_W'(clamp_weight(v, nn));
        r.w2 = WGT_W'(clamp_weight(w, nn));
        r.w3 = WGT_W'(clamp_weight(u, nn));
        return r;
    endfunction

    function automatic tri_item_t noise_item();
        tri_item_t it;
        it.cmd = cmd_t'($urandom_range(0, 1));
        it.sel = 2'($urandom);
        it.vx = $urandom; it.vy = $urandom; it.vz = $urandom;
        it.ox = $urandom; it.oy = $urandom; it.oz = $urandom;
        it.dx = $urandom; it.dy = $urandom; it.dz = $urandom;
        it.maxd = DIST_W'($urandom);
        return it;
    endfunction

    // unused fields carry random values
    function automatic tri_item_t mk_load(logic [1:0] sel, longint x, longint y, longint z);
        tri_item_t it;
        it = noise_item();
        it.cmd = CMD_LOAD;
        it.sel = sel;
        it.vx = IN_W'(x); it.vy = IN_W'(y); it.vz = IN_W'(z);
        return it;
    endfunction

    function automatic tri_item_t mk_ray(longint ox, longint oy, longint oz,
                                         longint dx, longint dy, longint dz,
                                         logic [DIST_W-1:0] maxd);
        tri_item_t it;
        it = noise_item();
        it.cmd = CMD_RAY;
        it.ox = IN_W'(ox); it.oy = IN_W'(oy); it.oz = IN_W'(oz);
        it.dx = IN_W'(dx); it.dy = IN_W'(dy); it.dz = IN_W'(dz);
        it.maxd = maxd;
        return it;
    endfunction

    function automatic void add_row(tri_item_t it, bit typed);
        stim_row_t row;
        row.item = it;
        row.typed = typed;
        row.want = miss_result();
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d want %0d (cycle %0d)", what, got, want, cycles);
        mismatches++;
    endtask

    // send one item and hold it until accepted; leaves the caller at the accepting edge
    task automatic send_item(tri_item_t it, bit typed, hit_result_t want);
        s_valid <= 1'b1;
        s_cmd <= it.cmd;
        s_vertex_sel <= it.sel;
        s_vert_x <= it.vx; s_vert_y <= it.vy; s_vert_z <= it.vz;
        s_origin_x <= it.ox; s_origin_y <= it.oy; s_origin_z <= it.oz;
        s_dir_x <= it.dx; s_dir_y <= it.dy; s_dir_z <= it.dz;
        s_max_distance <= it.maxd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (it.cmd == CMD_LOAD) begin
            if (it.sel < NUM_VERTS) begin
                tri_vert[it.sel].x = it.vx;
                tri_vert[it.sel].y = it.vy;
                tri_vert[it.sel].z = it.vz;
            end
        end else begin
            pending_hits.insert(pending_hits.size(), typed ? want : trace_ray(it));
        end
    endtask

    task automatic sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return;
        s_valid <= 1'b0;
        if (r < 90) repeat ($urandom_range(1, 3)) @(posedge aclk);
        else repeat ($urandom_range(10, 40)) @(posedge aclk);
    endtask

    task automatic push(tri_item_t it);
        send_item(it, 1'b0, miss_result());
        sender_gap();
    endtask

    task automatic drain_and_write(logic [DIST_W-1:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_hits.size() != 0) @(posedge aclk);
        repeat (RAY_LATENCY + 16) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        min_dist_reg = value;
    endtask

    // one triangle of moderate size, then rays aimed at it, mostly inside it
    task automatic triangle_burst();
        fvec_t pv [3];
        longint a, b, tx, ty, tz, ox, oy, oz;
        int nrays, k;
        logic [DIST_W-1:0] maxd;
        for (k = 0; k < 3; k++) begin
            pv[k].x = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            pv[k].y = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            pv[k].z = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            push(mk_load(2'(k), pv[k].x, pv[k].y, pv[k].z));
        end
        if ($urandom_range(0, 9) == 0) push(mk_load(2'd3, $urandom, $urandom, $urandom));
        nrays = $urandom_range(4, 8);
        for (k = 0; k < nrays; k++) begin
            a = $urandom_range(0, 65536);
            b = $urandom_range(0, 65536 - a);
            if ($urandom_range(0, 5) == 0) a = a + 8000;
            tx = pv[0].x + (((pv[1].x - pv[0].x) * a) >>> 16) + (((pv[2].x - pv[0].x) * b) >>> 16);
            ty = pv[0].y + (((pv[1].y - pv[0].y) * a) >>> 16) + (((pv[2].y - pv[0].y) * b) >>> 16);
            tz = pv[0].z + (((pv[1].z - pv[0].z) * a) >>> 16) + (((pv[2].z - pv[0].z) * b) >>> 16);
            ox = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            oy = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            oz = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            maxd = ($urandom_range(0, 3) == 0) ? DIST_W'($urandom_range(0, 1 << 18))
                                               : DIST_ALL_ONES;
            if ($urandom_range(0, 1))
                push(mk_ray(ox, oy, oz, tx - ox, ty - oy, tz - oz, maxd));
            else
                push(mk_ray(ox, oy, oz, (tx - ox) >>> 1, (ty - oy) >>> 1, (tz - oz) >>> 1,
                            maxd));
        end
    endtask

    task automatic random_phase(int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 75) begin
                triangle_burst();
                sent += 9;
            end else begin
                push(noise_item());
                sent++;
            end
        end
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result checker
    always @(posedge aclk) begin
        hit_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (pending_hits.size() == 0) begin
                report_mismatch("unexpected item", m_hit, -1);
            end else begin
                want = pending_hits.pop_front();
                if (m_hit !== want.hit) report_mismatch("hit", m_hit, want.hit);
                if (m_hit_distance !== want.distance)
                    report_mismatch("hit_distance", m_hit_distance, want.distance);
                if (m_weight_first !== want.w1)
                    report_mismatch("weight_first", m_weight_first, want.w1);
                if (m_weight_second !== want.w2)
                    report_mismatch("weight_second", m_weight_second, want.w2);
                if (m_weight_third !== want.w3)
                    report_mismatch("weight_third", m_weight_third, want.w3);
            end
        end
    end

    // result side back-pressure, with one long hold-off
    initial begin
        int r;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            r = $urandom_range(0, 99);
            if (!hold_done && results_seen >= 60) begin
                m_ready <= 1'b0;
                repeat (600) @(posedge aclk);
                hold_done = 1'b1;
            end else if (r < 60) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end else if (r < 95) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(20, 60)) @(posedge aclk);
            end
        end
    end

    initial begin
        stim_row_t row;
        longint one;
        int k;

        one = 65536;
        for (k = 0; k < NUM_VERTS; k++) tri_vert[k] = '{0, 0, 0};
        min_dist_reg = MIN_DIST_RESET;

        // degenerate triangle right after reset
        add_row(mk_ray(0, 0, one, 0, 0, -one, DIST_ALL_ONES), 1'b1);
        add_row(mk_load(2'd0, 0, 0, 0), 1'b0);
        add_row(mk_load(2'd1, one, 0, 0), 1'b0);
        add_row(mk_load(2'd2, 0, one, 0), 1'b0);
        // invalid select leaves the triangle alone
        add_row(mk_load(2'd3, FX_HI, FX_LO, FX_HI), 1'b0);
        add_row(mk_ray(one / 4, one / 4, one, 0, 0, -one, DIST_ALL_ONES), 1'b0);
        add_row(mk_ray(one / 3, one / 3, 2 * one, 0, 0, -one, DIST_ALL_ONES), 1'b0);
        // parallel ray
        add_row(mk_ray(0, 0, one, one, 0, 0, DIST_ALL_ONES), 1'b1);
        // origin on the plane: t below min_distance
        add_row(mk_ray(one / 4, one / 4, 0, 0, 0, -one, DIST_ALL_ONES), 1'b1);
        // hit beyond max_distance
        add_row(mk_ray(one / 4, one / 4, 4 * one, 0, 0, -one, 31'd65536), 1'b1);
        add_row(mk_ray(one / 4, one / 4, 4 * one, 0, 0, -one, 31'd262144), 1'b0);
        // outside the triangle, at a vertex, from behind
        add_row(mk_ray(one, one, one, 0, 0, -one, DIST_ALL_ONES), 1'b0);
        add_row(mk_ray(0, 0, one, 0, 0, -one, DIST_ALL_ONES), 1'b0);
        add_row(mk_ray(one / 4, one / 4, -one, 0, 0, one, DIST_ALL_ONES), 1'b0);
        add_row(mk_ray(FX_HI, FX_LO, FX_HI, FX_LO, FX_HI, FX_LO, DIST_ALL_ONES), 1'b0);
        add_row(mk_ray(0, 0, FX_HI, 0, 0, -1, 31'd0), 1'b0);
        // extreme vertices
        add_row(mk_load(2'd0, FX_LO, FX_LO, FX_LO), 1'b0);
        add_row(mk_load(2'd1, FX_HI, FX_LO, 0), 1'b0);
        add_row(mk_load(2'd2, FX_LO, FX_HI, FX_HI), 1'b0);
        add_row(mk_ray(0, 0, 0, 1, 1, 1, DIST_ALL_ONES), 1'b0);
        add_row(mk_ray(-1, -1, -1, FX_LO, FX_LO, FX_HI, DIST_ALL_ONES), 1'b0);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[i]) begin
            row = stim_rows[i];
            send_item(row.item, row.typed, row.want);
            sender_gap();
        end
        random_phase(ITEMS_PER_PHASE);

        drain_and_write(31'd0);
        random_phase(ITEMS_PER_PHASE);
        drain_and_write(DIST_W'($urandom_range(1, 1 << 17)));
        random_phase(ITEMS_PER_PHASE);
        drain_and_write(DIST_ALL_ONES);
        random_phase(ITEMS_PER_PHASE / 2);
        drain_and_write(MIN_DIST_RESET);
        random_phase(ITEMS_PER_PHASE);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_hits.size() != 0) @(posedge aclk);
        repeat (RAY_LATENCY + 16) @(posedge aclk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
